### hw/rtl/dip_pkg.sv
package dip_pkg;

  // internal sample width, the top of the sample width range
  localparam int SAMPLE_W  = 32;
  localparam int CORD_W    = SAMPLE_W + 27;
  localparam int ZW        = 34;
  localparam int MAG_W     = 48;
  localparam int PHASE_W   = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int Q_DEPTH   = 2;
  localparam int PRESCALE  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RTIA_MAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RTIA_PHASE = 2'd1;

  localparam logic [MAG_W-1:0] MAG_FULL = {MAG_W{1'b1}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CORD_W-1:0]   cord_t;
  typedef logic signed [ZW-1:0]       phase_z_t;

  typedef struct packed {
    sample_t ir;
    sample_t ii;
    sample_t vr;
    sample_t vi;
    logic    batch_end;
    logic    i_zero;
    logic    v_zero;
  } item_t;

  localparam phase_z_t HALF_PI_Q30 = 34'sd1686629713;

  // atan(2^-i) in 2^-30 rad
  function automatic phase_z_t atan_q30(input logic [4:0] idx);
    phase_z_t a;
    unique case (idx)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [SAMPLE_W-1:0] abs_sample(input sample_t s);
    logic [SAMPLE_W-1:0] r;
    r = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
    return r;
  endfunction

endpackage

### hw/rtl/dip_front.sv
module dip_front #(
  parameter int SAMPLE_BITS = 18
) (
  input  logic [31:0]    current_real_word,
  input  logic [31:0]    current_imag_word,
  input  logic [31:0]    voltage_real_word,
  input  logic [31:0]    voltage_imag_word,
  input  logic           batch_end,
  output dip_pkg::item_t item
);

  logic signed [SAMPLE_BITS-1:0] s_ir, s_ii, s_vr, s_vi;

  assign s_ir = current_real_word[SAMPLE_BITS-1:0];
  assign s_ii = current_imag_word[SAMPLE_BITS-1:0];
  assign s_vr = voltage_real_word[SAMPLE_BITS-1:0];
  assign s_vi = voltage_imag_word[SAMPLE_BITS-1:0];

  // sign extend and flag zero vectors
  always_comb begin
    item.ir        = dip_pkg::sample_t'(s_ir);
    item.ii        = dip_pkg::sample_t'(s_ii);
    item.vr        = dip_pkg::sample_t'(s_vr);
    item.vi        = dip_pkg::sample_t'(s_vi);
    item.batch_end = batch_end;
    item.i_zero    = (s_ir == '0) && (s_ii == '0);
    item.v_zero    = (s_vr == '0) && (s_vi == '0);
  end

endmodule

### hw/rtl/dip_queue.sv
module dip_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  dip_pkg::item_t       push_item,
  output logic                 pop_valid,
  input  logic                 pop,
  output dip_pkg::item_t       pop_item,
  output logic [1:0]           count
);

  dip_pkg::item_t mem_r [dip_pkg::Q_DEPTH];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push, do_pop;

  assign push_ready = (count_r != 2'(dip_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign count      = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

### hw/rtl/dip_cordic.sv
module dip_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dip_pkg::sample_t  re,
  input  dip_pkg::sample_t  im,
  input  logic              zero,
  output dip_pkg::phase_z_t z,
  output logic              done
);

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  dip_pkg::cord_t    x_r, y_r, x0, y0, ys, dx, dy;
  dip_pkg::phase_z_t z_r, z0;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r, done_r;

  // scale and turn into the right half plane; y is the negated imaginary part
  always_comb begin
    dip_pkg::cord_t xs;
    xs = dip_pkg::cord_t'(re) <<< dip_pkg::PRESCALE;
    ys = -(dip_pkg::cord_t'(im) <<< dip_pkg::PRESCALE);
    x0 = xs;
    y0 = ys;
    z0 = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0 = ys;
        y0 = -xs;
        z0 = dip_pkg::HALF_PI_Q30;
      end else begin
        x0 = -ys;
        y0 = xs;
        z0 = -dip_pkg::HALF_PI_Q30;
      end
    end
  end

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= !zero;
      done_r <= zero;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= zero ? '0 : z0;
    end else if (run_r) begin
      if (y_r >= 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + dip_pkg::atan_q30(5'(cnt_r));
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - dip_pkg::atan_q30(5'(cnt_r));
      end
    end
  end

  assign z    = z_r;
  assign done = done_r;

endmodule

### hw/rtl/dip_back.sv
module dip_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  dip_pkg::item_t                    q_item,
  output logic                              q_pop,
  input  logic [31:0]                       rtia_mag,
  input  logic signed [15:0]                rtia_phase,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dip_pkg::MAG_W-1:0]         out_mag,
  output logic signed [dip_pkg::PHASE_W-1:0] out_phase,
  output logic                              out_izero,
  output logic                              out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CHECK, S_DIV, S_SQRT, S_WAIT
  } state_t;

  // multiply sequence steps
  localparam logic [6:0] M_IR = 7'd0, M_II = 7'd1, M_VR = 7'd2, M_VI = 7'd3;
  localparam logic [6:0] M_R2 = 7'd4, M_LL = 7'd5, M_LH = 7'd6, M_HL = 7'd7;
  localparam logic [6:0] M_HH = 7'd8;
  localparam logic [6:0] DIV_LAST  = 7'd95;
  localparam logic [6:0] SQRT_LAST = 7'd47;

  state_t          state_r;
  logic [6:0]      cnt_r;
  dip_pkg::item_t  item_r;
  logic [63:0]     i2_r, v2_r, r2_r;
  logic [127:0]    acc_r;
  logic [63:0]     rem_r;
  logic [51:0]     sqr_r;
  logic [47:0]     root_r;
  logic            full_r;
  logic            out_valid_r, out_izero_r, out_last_r;
  logic [dip_pkg::MAG_W-1:0]          out_mag_r;
  logic signed [dip_pkg::PHASE_W-1:0] out_phase_r;

  logic [31:0]     op_a, op_b;
  logic [63:0]     prod;
  logic [127:0]    acc_nxt;
  logic [64:0]     div_sh, div_diff;
  logic            div_ge, sq_ge, sat;
  logic [51:0]     sq_sh, sq_trial, sq_diff;
  logic signed [35:0] ph_sum;
  dip_pkg::phase_z_t  z_v, z_i;
  logic            done_v, done_i, start, out_free;

  assign start    = (state_r == S_IDLE) && q_valid;
  assign q_pop    = start;
  assign out_free = !out_valid_r || out_ready;

  dip_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_v (
    .clk(clk), .rst_n(rst_n), .start(start), .re(q_item.vr), .im(q_item.vi),
    .zero(q_item.v_zero), .z(z_v), .done(done_v)
  );

  dip_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_i (
    .clk(clk), .rst_n(rst_n), .start(start), .re(q_item.ir), .im(q_item.ii),
    .zero(q_item.i_zero), .z(z_i), .done(done_i)
  );

  // shared 32x32 multiplier
  always_comb begin
    unique case (cnt_r)
      M_IR: begin op_a = dip_pkg::abs_sample(item_r.ir); op_b = op_a; end
      M_II: begin op_a = dip_pkg::abs_sample(item_r.ii); op_b = op_a; end
      M_VR: begin op_a = dip_pkg::abs_sample(item_r.vr); op_b = op_a; end
      M_VI: begin op_a = dip_pkg::abs_sample(item_r.vi); op_b = op_a; end
      M_R2: begin op_a = rtia_mag;     op_b = rtia_mag;     end
      M_LL: begin op_a = v2_r[31:0];   op_b = r2_r[31:0];   end
      M_LH: begin op_a = v2_r[31:0];   op_b = r2_r[63:32];  end
      M_HL: begin op_a = v2_r[63:32];  op_b = r2_r[31:0];   end
      M_HH: begin op_a = v2_r[63:32];  op_b = r2_r[63:32];  end
      default: begin op_a = '0; op_b = '0; end
    endcase
    prod = 64'(op_a) * 64'(op_b);
    unique case (cnt_r)
      M_LL:        acc_nxt = 128'(prod);
      M_LH, M_HL:  acc_nxt = acc_r + (128'(prod) << 32);
      M_HH:        acc_nxt = acc_r + (128'(prod) << 64);
      default:     acc_nxt = acc_r;
    endcase
  end

  // restoring division and root, one bit each per cycle
  always_comb begin
    sat      = ({32'd0, acc_r[127:96]} >= i2_r);
    div_sh   = {rem_r, acc_r[95]};
    div_ge   = div_sh >= {1'b0, i2_r};
    div_diff = div_sh - {1'b0, i2_r};
    sq_sh    = {sqr_r[49:0], acc_r[95:94]};
    sq_trial = {2'b00, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_diff  = sq_sh - sq_trial;
    ph_sum   = 36'(z_v) - 36'(z_i) + (36'(rtia_phase) <<< 17) + 36'sd65536;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            cnt_r   <= M_IR;
            full_r  <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (cnt_r)
            M_IR:    i2_r <= prod;
            M_II:    i2_r <= i2_r + prod;
            M_VR:    v2_r <= prod;
            M_VI:    v2_r <= v2_r + prod;
            M_R2:    r2_r <= prod;
            default: acc_r <= acc_nxt;
          endcase
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == M_HH) state_r <= S_CHECK;
        end
        S_CHECK: begin
          cnt_r <= '0;
          if (item_r.i_zero || sat) begin
            full_r  <= 1'b1;
            state_r <= S_WAIT;
          end else begin
            rem_r   <= {32'd0, acc_r[127:96]};
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r        <= div_ge ? div_diff[63:0] : div_sh[63:0];
          acc_r[95:0]  <= {acc_r[94:0], div_ge};
          cnt_r        <= cnt_r + 7'd1;
          if (cnt_r == DIV_LAST) begin
            cnt_r   <= '0;
            sqr_r   <= '0;
            root_r  <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          sqr_r       <= sq_ge ? sq_diff : sq_sh;
          root_r      <= {root_r[46:0], sq_ge};
          acc_r[95:0] <= {acc_r[93:0], 2'b00};
          cnt_r       <= cnt_r + 7'd1;
          if (cnt_r == SQRT_LAST) state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (done_v && done_i && out_free) begin
            out_valid_r <= 1'b1;
            out_mag_r   <= full_r ? dip_pkg::MAG_FULL : root_r;
            out_phase_r <= ph_sum[34:17];
            out_izero_r <= item_r.i_zero;
            out_last_r  <= item_r.batch_end;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_mag   = out_mag_r;
  assign out_phase = out_phase_r;
  assign out_izero = out_izero_r;
  assign out_last  = out_last_r;

endmodule

### hw/rtl/dft_impedance_polar.sv
// dft_impedance_polar: impedance in polar form from one set of dft results
//
// input channel (in_valid/in_ready): four raw dft words (current re/im,
//   voltage re/im, low SAMPLE_BITS bits two's complement) and a batch end
//   marker. items enter a two-entry queue, so in_ready is low only when
//   the queue is full.
// output channel (out_valid/out_ready): magnitude in 1/256 ohm (saturated),
//   phase in 2^-13 rad, zero-current flag and the batch marker.
// config channel (cfg_valid/cfg_ready): index 0 rtia magnitude, 1 rtia
//   phase; always ready; written by the user only while idle, unchecked.
// an item goes from the queue head through the shared 32x32 multiplier,
//   the bit-serial divider and the bit-serial square root; a zero current
//   or saturated magnitude skips the divider and root. the result is
//   registered once both cordic units are done and the output is free;
//   the back end takes its next item only after that.
// reset clears the queue, the sequencer and both rtia registers.
// when out_ready is low the result holds in the output register; the back
//   end finishes its next item and waits; the queue takes items until full.
module dft_impedance_polar #(
  parameter int SAMPLE_BITS  = 18,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         in_current_real_word,
  input  logic [31:0]                         in_current_imag_word,
  input  logic [31:0]                         in_voltage_real_word,
  input  logic [31:0]                         in_voltage_imag_word,
  input  logic                                in_batch_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dip_pkg::MAG_W-1:0]           out_impedance_magnitude,
  output logic signed [dip_pkg::PHASE_W-1:0]  out_impedance_phase,
  output logic                                out_current_zero,
  output logic                                out_batch_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dip_pkg::CFG_W-1:0]           cfg_data
);

  logic [31:0]        rtia_mag_r;
  logic signed [15:0] rtia_phase_r;
  dip_pkg::item_t     front_item, head_item;
  logic               head_valid, head_pop;
  logic [1:0]         q_count;

  // configuration registers, a write to an unknown index is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtia_mag_r   <= '0;
      rtia_phase_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == dip_pkg::REG_RTIA_MAG)   rtia_mag_r   <= cfg_data;
      if (cfg_index == dip_pkg::REG_RTIA_PHASE) rtia_phase_r <= cfg_data[15:0];
    end
  end

  // front: sign extension and zero-vector flags
  dip_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .current_real_word(in_current_real_word),
    .current_imag_word(in_current_imag_word),
    .voltage_real_word(in_voltage_real_word),
    .voltage_imag_word(in_voltage_imag_word),
    .batch_end(in_batch_end),
    .item(front_item)
  );

  // queue between front and back
  dip_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(in_valid), .push_ready(in_ready), .push_item(front_item),
    .pop_valid(head_valid), .pop(head_pop), .pop_item(head_item),
    .count(q_count)
  );

  // back: multiplier, divider, root and the two cordic units
  dip_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(head_valid), .q_item(head_item), .q_pop(head_pop),
    .rtia_mag(rtia_mag_r), .rtia_phase(rtia_phase_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_mag(out_impedance_magnitude), .out_phase(out_impedance_phase),
    .out_izero(out_current_zero), .out_last(out_batch_last)
  );

  // zero current always comes with a saturated magnitude
  a_izero_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_current_zero |-> out_impedance_magnitude == dip_pkg::MAG_FULL)
    else $error("zero current without saturated magnitude");

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 2'(dip_pkg::Q_DEPTH))
    else $error("queue count above depth");

  // a refused item means the queue is full
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> q_count == 2'(dip_pkg::Q_DEPTH))
    else $error("input refused with room in queue");

  // an accepted item into an empty queue is visible next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && q_count == 2'd0 |=> head_valid)
    else $error("accepted item lost");

endmodule

### tb/sv/dft_impedance_polar_test.sv
module dft_impedance_polar_test;

  localparam int WORD_BITS   = 18;   // sample width the block is built with
  localparam int ANGLE_STEPS = 16;   // cordic iterations of the block
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic [dip_pkg::MAG_W-1:0]   mag;
    logic [dip_pkg::PHASE_W-1:0] phase;
    logic                        czero;
    logic                        blast;
  } polar_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         in_current_real_word;
  logic [31:0]         in_current_imag_word;
  logic [31:0]         in_voltage_real_word;
  logic [31:0]         in_voltage_imag_word;
  logic                in_batch_end;
  logic                out_valid;
  logic                out_ready;
  logic [dip_pkg::MAG_W-1:0]    out_impedance_magnitude;
  logic signed [dip_pkg::PHASE_W-1:0] out_impedance_phase;
  logic                out_current_zero;
  logic                out_batch_last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [dip_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dip_pkg::CFG_W-1:0]    cfg_data;

  // our copy of the two rtia registers
  logic [31:0] rtia_mag_q;
  logic [15:0] rtia_ph_q;

  polar_t pending_polar[$];
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_cycles;
  int     quiet_cycles;
  bit     failed;

  dft_impedance_polar DUT (.*);

  // clock, period 8
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // low SAMPLE bits, two's complement
  function automatic longint sext_word(input logic [31:0] w);
    logic [WORD_BITS-1:0] v;
    v = w[WORD_BITS-1:0];
    return longint'($signed(v));
  endfunction

  // atan2(y, x) in 2^-30 rad, vectoring cordic
  function automatic longint cordic_angle(input longint x0, input longint y0);
    longint x, y, z, t, dx, dy;
    longint angles[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    if (x0 == 0 && y0 == 0) return 0;
    x = x0 <<< 24;
    y = y0 <<< 24;
    z = 0;
    // left half plane: rotate by a quarter turn first
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;  y = -t; z = 1686629713;
      end else begin
        x = -y; y = t;  z = -1686629713;
      end
    end
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += angles[i];
      end else begin
        x -= dx; y += dy; z -= angles[i];
      end
    end
    return z;
  endfunction

  // expected polar impedance for one set of dft words
  function automatic polar_t impedance_of(input logic [31:0] cr, ci, vr, vi,
                                          input logic be);
    polar_t r;
    longint ir, ii, xr, xi, ph, rp;
    logic [159:0] i2, v2, rhs, lhs, t;
    logic [dip_pkg::MAG_W-1:0] m;
    ir = sext_word(cr); ii = sext_word(ci);
    xr = sext_word(vr); xi = sext_word(vi);
    i2 = 160'(ir * ir) + 160'(ii * ii);
    v2 = 160'(xr * xr) + 160'(xi * xi);
    m = '0;
    if (i2 == 0) begin
      m = '1;
    end else begin
      rhs = v2 * 160'(rtia_mag_q) * 160'(rtia_mag_q);
      // largest m with i2*m^2 <= v2*rtia^2, saturates at all ones
      for (int b = dip_pkg::MAG_W - 1; b >= 0; b--) begin
        t = 160'(m) | (160'(1) << b);
        lhs = i2 * t * t;
        if (lhs <= rhs) m = t[dip_pkg::MAG_W-1:0];
      end
    end
    rp = longint'($signed(rtia_ph_q));
    ph = cordic_angle(xr, -xi) - cordic_angle(ir, -ii) + (rp <<< 17);
    ph = (ph + 65536) >>> 17;
    r.mag   = m;
    r.phase = ph[dip_pkg::PHASE_W-1:0];
    r.czero = (i2 == 0);
    r.blast = be;
    return r;
  endfunction

  // one item; valid stays up between back-to-back items
  task automatic send_item(input logic [31:0] cr, ci, vr, vi, input logic be);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_current_real_word <= cr;
    in_current_imag_word <= ci;
    in_voltage_real_word <= vr;
    in_voltage_imag_word <= vi;
    in_batch_end         <= be;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_polar.push_back(impedance_of(cr, ci, vr, vi, be));
  endtask

  // let everything drain before touching registers
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_polar.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dip_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == dip_pkg::REG_RTIA_MAG) rtia_mag_q = d;
    else if (idx == dip_pkg::REG_RTIA_PHASE) rtia_ph_q = d[15:0];
    @(posedge clk);
  endtask

  task automatic set_rtia(input logic [31:0] mag, input logic [31:0] ph);
    drain();
    write_reg(dip_pkg::REG_RTIA_MAG, mag);
    write_reg(dip_pkg::REG_RTIA_PHASE, ph);
  endtask

  // random word: full 32 bits, or small magnitudes with garbage upper bits
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int sh;
    w = $urandom;
    case ($urandom_range(3))
      0: begin
        sh = $urandom_range(17);
        w = (w & 32'hfffc0000) | (32'(($signed(w << 14) >>> 14) >>> sh) & 32'h3ffff);
      end
      1: w = $urandom_range(1) ? 32'h0 : 32'hfffc0000;
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_extremes;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_rtia(32'd256, 32'd0);
    // zero vectors everywhere: zero current flag, phase zero
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    // zero current with live voltage
    send_item(32'hfffc0000, 32'h0, 32'h0001ffff, 32'h00020000, 1'b1);
    // most negative and most positive samples
    send_item(32'h00020000, 32'h00020000, 32'h0001ffff, 32'h0001ffff, 1'b0);
    send_item(32'h0001ffff, 32'h0001ffff, 32'h00020000, 32'h00020000, 1'b1);
    // negative real axis, imag zero
    send_item(32'h3ffff, 32'h0, 32'h00020000, 32'h0, 1'b0);
    send_item(32'h00020000, 32'h0, 32'h1, 32'h0, 1'b0);
    // quadrant crossings
    send_item(32'h1, 32'h3ffff, 32'h3ffff, 32'h1, 1'b0);
    send_item(32'h3ffff, 32'h3ffff, 32'h1, 32'h1, 1'b1);
    // upper garbage bits ignored
    send_item(32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'hdeadbeef, 1'b1);
    // tiny current, huge voltage, large rtia: saturation
    set_rtia(32'hffffffff, 32'd25736);
    send_item(32'h1, 32'h0, 32'h00020000, 32'h00020000, 1'b0);
    send_item(32'h00020000, 32'h0, 32'h1, 32'h0, 1'b0);
    send_item(32'h0, 32'h0, 32'h12345, 32'h3, 1'b1);
    set_rtia(32'd0, 32'hffff9b78);  // -25736
    send_item(32'h00020000, 32'h0001ffff, 32'h00020000, 32'h0, 1'b0);
    send_item(32'h1234, 32'h3ffff, 32'h5, 32'h00020000, 1'b1);
    // out-of-range phase register, upper data bits dropped
    set_rtia(32'd1, 32'h5a5a8000);
    send_item(32'h00020000, 32'h0, 32'h0001ffff, 32'h1, 1'b0);
    set_rtia(32'd1, 32'h00007fff);
    send_item(32'h1, 32'h0, 32'h00020000, 32'h3ffff, 1'b0);
  endtask

  // receiver stops for a long time while the sender keeps offering
  task automatic test_backpressure;
    set_rtia(32'd300000, 32'd1234);
    send_idle_pct = 0;
    hold_cycles <= 1500;
    for (int n = 0; n < 12; n++)
      send_item(rand_word(), rand_word(), rand_word(), rand_word(), $urandom_range(1));
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int n = 0; n < count; n++)
      send_item(rand_word(), rand_word(), rand_word(), rand_word(), $urandom_range(1));
  endtask

  // receiver: random stalls, or a counted long hold
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    polar_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_polar.size() == 0) begin
        $display("%0t unexpected result mag=%h phase=%h", $time,
                 out_impedance_magnitude, out_impedance_phase);
        failed = 1'b1;
      end else begin
        e = pending_polar.pop_front();
        if (out_impedance_magnitude !== e.mag) begin
          $display("%0t magnitude expected %h actual %h", $time, e.mag,
                   out_impedance_magnitude);
          failed = 1'b1;
        end
        if (out_impedance_phase !== e.phase) begin
          $display("%0t phase expected %h actual %h", $time, e.phase,
                   out_impedance_phase);
          failed = 1'b1;
        end
        if (out_current_zero !== e.czero) begin
          $display("%0t current_zero expected %b actual %b", $time, e.czero,
                   out_current_zero);
          failed = 1'b1;
        end
        if (out_batch_last !== e.blast) begin
          $display("%0t batch_last expected %b actual %b", $time, e.blast,
                   out_batch_last);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("dft_impedance_polar_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    failed = 1'b0;
    rtia_mag_q = '0;
    rtia_ph_q = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_current_real_word = '0;
    in_current_imag_word = '0;
    in_voltage_real_word = '0;
    in_voltage_imag_word = '0;
    in_batch_end = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_backpressure();
    set_rtia(32'd2560000, 32'd25736);
    test_random(500, 18, 64);
    set_rtia($urandom, 32'(-int'($urandom_range(25736))));
    test_random(500, 64, 18);
    set_rtia(32'hffffffff, 32'hffff9b78);
    test_random(500, 0, 0);

    drain();
    if (!failed) begin
      $display("dft_impedance_polar_test: PASS");
    end else begin
      $display("dft_impedance_polar_test: FAIL");
    end
    $finish;
  end

endmodule
